// File: design/aocf_pkg.sv
// Package for the associative object table: payload types, entry layout, sequencer states.
`default_nettype none
package aocf_pkg;

  localparam int ENTRIES_DEF      = 8;
  localparam int OBJECT_LIMIT_DEF = 131072;

  localparam int KEY_W  = 64;
  localparam int DATA_W = 64;
  localparam int SIZE_W = 18;
  localparam int AGE_W  = 64;
  localparam int SLOT_W = 3;

  typedef enum logic {
    FUNC_LOOKUP = 1'b0,
    FUNC_INSERT = 1'b1
  } func_t;

  typedef struct packed {
    func_t              func;
    logic [KEY_W-1:0]   key_word;
    logic [DATA_W-1:0]  data_word;
    logic [SIZE_W-1:0]  obj_size;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic [DATA_W-1:0]  found_data;
    logic [SIZE_W-1:0]  found_size;
  } rsp_t;

  // One table entry as stored in the RAM.
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [DATA_W-1:0]  data;
    logic [SIZE_W-1:0]  size;
    logic [AGE_W-1:0]   age;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage
`default_nettype wire

// File: design/aocf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module aocf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: design/assoc_object_cache_fifo_evict_unit.sv
// Top level of the fully associative object table with FIFO replacement.
//
// Request channel (req_valid / req_stall / req): one transfer is a lookup or
// an insert. Response channel (rsp_valid / rsp_stall / rsp): exactly one
// transfer per request, in request order.
// Each request walks the table one slot per cycle through a single RAM read
// port: one key compare and one age compare per cycle. A request goes through
// accept, ENTRIES reads, a tail step for the last read's data and a finish step
// (table write on insert). req_stall is high whenever a request is in progress.
// Insert: picks the lowest empty slot (size zero), else the oldest slot,
// lowest index on a tie, and writes key, handle, clamped size and age there.
// Lookup: reports the lowest non-empty slot with a matching key.
// Reset (rst, synchronous) empties every slot through per-slot valid flops
// and clears the age counter; no clearing pass is needed. The RAM contents
// are left alone.
// A stalled response is held in the output register; the next request can
// still be taken, and it then waits in its finish cycle until that register
// frees up.
`default_nettype none
module assoc_object_cache_fifo_evict_unit #(
  parameter int ENTRIES      = aocf_pkg::ENTRIES_DEF,
  parameter int OBJECT_LIMIT = aocf_pkg::OBJECT_LIMIT_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output      logic          req_stall,
  input  wire aocf_pkg::req_t req,
  output      logic          rsp_valid,
  input  wire logic          rsp_stall,
  output      aocf_pkg::rsp_t rsp
);

  localparam int IDXW   = $clog2(ENTRIES);
  localparam int LIMW   = $clog2(OBJECT_LIMIT + 1);
  // width wide enough for both the size field and the limit
  localparam int CMPW   = (LIMW > aocf_pkg::SIZE_W) ? LIMW : aocf_pkg::SIZE_W;
  localparam int ENT_W  = $bits(aocf_pkg::entry_t);

  localparam logic [IDXW:0]   CNT_END = (IDXW + 1)'(ENTRIES);
  localparam logic [CMPW-1:0] LIMIT   = CMPW'(OBJECT_LIMIT);

  aocf_pkg::state_t state, state_next;

  // latched request
  aocf_pkg::req_t item;

  logic [aocf_pkg::AGE_W-1:0] insert_count;
  logic [ENTRIES-1:0]         slot_vld;

  // scan pointer and read-data tag
  logic [IDXW:0]   scan_cnt;
  logic            chk_vld;
  logic [IDXW-1:0] chk_idx;

  // scan trackers
  logic                        empty_found;
  logic [IDXW-1:0]             empty_idx;
  logic                        best_vld;
  logic [IDXW-1:0]             best_idx;
  logic [aocf_pkg::AGE_W-1:0]  best_age;
  logic                        found;
  logic [IDXW-1:0]             found_idx;
  logic [aocf_pkg::DATA_W-1:0] found_data;
  logic [aocf_pkg::SIZE_W-1:0] found_size;

  // control
  logic            accept;
  logic            rd_en;
  logic            finish_go;
  logic            wr_en;
  logic [IDXW-1:0] victim;

  aocf_pkg::entry_t rd_ent, wr_ent;
  logic [ENT_W-1:0] rd_bits;

  logic [CMPW-1:0]             size_ext;
  logic [aocf_pkg::SIZE_W-1:0] size_sat;

  assign accept = req_valid && !req_stall;
  assign rd_ent = aocf_pkg::entry_t'(rd_bits);
  assign victim = empty_found ? empty_idx : best_idx;

  // clamp oversized inserts
  assign size_ext = CMPW'(item.obj_size);
  assign size_sat = (size_ext > LIMIT) ? LIMIT[aocf_pkg::SIZE_W-1:0] : item.obj_size;

  assign wr_ent.key  = item.key_word;
  assign wr_ent.data = item.data_word;
  assign wr_ent.size = size_sat;
  assign wr_ent.age  = insert_count;

  aocf_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (victim),
    .wdata (wr_ent),
    .re    (rd_en),
    .raddr (scan_cnt[IDXW-1:0]),
    .rdata (rd_bits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aocf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    rd_en      = 1'b0;
    finish_go  = 1'b0;
    wr_en      = 1'b0;
    case (state)
      aocf_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          state_next = aocf_pkg::ST_SCAN;
        end
      end
      aocf_pkg::ST_SCAN: begin
        rd_en = (scan_cnt != CNT_END);
        // last slot's data is being checked this cycle
        if (scan_cnt == CNT_END && chk_vld) begin
          state_next = aocf_pkg::ST_FINISH;
        end
      end
      aocf_pkg::ST_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          finish_go  = 1'b1;
          wr_en      = (item.func == aocf_pkg::FUNC_INSERT);
          state_next = aocf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = aocf_pkg::ST_IDLE;
      end
    endcase
  end

  // request capture and age counter
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req;
    end
    if (rst) begin
      insert_count <= '0;
    end else if (accept && req.func == aocf_pkg::FUNC_INSERT) begin
      insert_count <= insert_count + 1'b1;
    end
  end

  // scan pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
      chk_vld  <= 1'b0;
    end else if (accept) begin
      scan_cnt <= '0;
      chk_vld  <= 1'b0;
    end else begin
      chk_vld <= rd_en;
      if (rd_en) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
    end
    if (rd_en) begin
      chk_idx <= scan_cnt[IDXW-1:0];
    end
  end

  // scan trackers: first empty, oldest, first key match
  always_ff @(posedge clk) begin
    if (rst || accept) begin
      empty_found <= 1'b0;
      best_vld    <= 1'b0;
      found       <= 1'b0;
    end else if (state == aocf_pkg::ST_SCAN && chk_vld) begin
      if (!slot_vld[chk_idx]) begin
        if (!empty_found) begin
          empty_found <= 1'b1;
          empty_idx   <= chk_idx;
        end
      end else begin
        if (!best_vld || rd_ent.age < best_age) begin
          best_vld <= 1'b1;
          best_age <= rd_ent.age;
          best_idx <= chk_idx;
        end
        if (!found && rd_ent.key == item.key_word) begin
          found      <= 1'b1;
          found_idx  <= chk_idx;
          found_data <= rd_ent.data;
          found_size <= rd_ent.size;
        end
      end
    end
  end

  // a slot is occupied when its stored size is non-zero
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld <= '0;
    end else if (wr_en) begin
      slot_vld[victim] <= (size_sat != '0);
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish_go) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (finish_go) begin
      if (item.func == aocf_pkg::FUNC_INSERT) begin
        rsp.hit        <= 1'b0;
        rsp.slot       <= aocf_pkg::SLOT_W'(victim);
        rsp.found_data <= '0;
        rsp.found_size <= '0;
      end else if (found) begin
        rsp.hit        <= 1'b1;
        rsp.slot       <= aocf_pkg::SLOT_W'(found_idx);
        rsp.found_data <= found_data;
        rsp.found_size <= found_size;
      end else begin
        rsp.hit        <= 1'b0;
        rsp.slot       <= '0;
        rsp.found_data <= '0;
        rsp.found_size <= '0;
      end
    end
  end

  // a new response is only produced out of the finish cycle
  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == aocf_pkg::ST_FINISH))
    else $error("response raised outside finish");

  // a hit always carries a non-empty slot
  a_hit_size: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.hit |-> rsp.found_size != '0)
    else $error("hit with zero size");

  // a full table must have produced an oldest candidate
  a_victim_known: assert property (@(posedge clk) disable iff (rst)
    state == aocf_pkg::ST_FINISH && item.func == aocf_pkg::FUNC_INSERT && !empty_found
    |-> best_vld)
    else $error("no victim for insert");

  // an accepted request starts a scan from slot zero
  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == aocf_pkg::ST_SCAN && scan_cnt == '0 && !chk_vld)
    else $error("scan did not start");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == aocf_pkg::ST_SCAN |-> scan_cnt <= CNT_END)
    else $error("scan pointer past table");

endmodule
`default_nettype wire
